@@ rtl/rak_pkg.sv @@
// Shared types and constants for the rear Ackermann kinematics pipeline.
`default_nettype none

package rak_pkg;

  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 32;
  localparam int CW           = 52;  // CORDIC datapath width
  localparam int NLANES       = 4;   // wheels: front left/right, rear left/right

  // Register indexes, byte address 4*i
  localparam logic [2:0] REG_SPD_LIM   = 3'd0;
  localparam logic [2:0] REG_WHEELBASE = 3'd1;
  localparam logic [2:0] REG_TRACK     = 3'd2;
  localparam logic [2:0] REG_RADIUS    = 3'd3;
  localparam logic [2:0] REG_STEER_LIM = 3'd4;

  localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [17:0] HALF_PI_Q16 = 18'sd102944;

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
    30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
    30'd1024, 30'd512, 30'd256, 30'd128, 30'd64,
    30'd32, 30'd16, 30'd8, 30'd4, 30'd2
  };

  // Geometry pipe: inner arc (_in) and outer arc (_out) carried side by side.
  typedef struct packed {
    logic                   turn;
    logic                   left;
    logic                   v_neg;
    logic                   di_neg;
    logic [30:0]            av;
    logic [46:0]            b;
    logic [46:0]            di_mag;
    logic [46:0]            dout;
    logic signed [CW-1:0]   x_in;
    logic signed [CW-1:0]   y_in;
    logic signed [32:0]     z_in;
    logic signed [CW-1:0]   x_out;
    logic signed [CW-1:0]   y_out;
    logic signed [32:0]     z_out;
    logic [46:0]            hp_in;
    logic [46:0]            hq_in;
    logic [46:0]            hp_out;
    logic [46:0]            hq_out;
    logic [4:0]             s_in;
    logic [4:0]             s_out;
    logic [63:0]            n_in;
    logic [63:0]            r_in;
    logic [63:0]            n_out;
    logic [63:0]            r_out;
  } trk_t;

  typedef struct packed {
    logic signed [17:0]          la;
    logic signed [17:0]          ra;
    logic [NLANES-1:0]           neg;
    logic [NLANES-1:0][48:0]     mag;
  } fin_t;

  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
  } lane_t;

  typedef struct packed {
    logic signed [17:0]          la;
    logic signed [17:0]          ra;
    lane_t [NLANES-1:0]          lane;
  } dvp_t;

endpackage

`default_nettype wire

@@ rtl/rak_if.sv @@
// Request channel interfaces: velocity command in, wheel command out.
`default_nettype none

interface rak_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] forward_speed;
  logic signed [31:0] yaw_rate;
  modport source (output valid, forward_speed, yaw_rate, input ready);
  modport sink   (input valid, forward_speed, yaw_rate, output ready);
endinterface

interface rak_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] left_steer_angle;
  logic signed [17:0] right_steer_angle;
  logic signed [31:0] front_left_rate;
  logic signed [31:0] front_right_rate;
  logic signed [31:0] rear_left_rate;
  logic signed [31:0] rear_right_rate;
  modport source (output valid, left_steer_angle, right_steer_angle, front_left_rate,
                  front_right_rate, rear_left_rate, rear_right_rate, input ready);
  modport sink   (input valid, left_steer_angle, right_steer_angle, front_left_rate,
                  front_right_rate, rear_left_rate, rear_right_rate, output ready);
endinterface

`default_nettype wire

@@ rtl/rak_norm_cell.sv @@
// Normalize cell: one binary step of CORDIC prescale and hypot downshift.
`default_nettype none

module rak_norm_cell #(
  parameter int K = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_in,
  input  wire rak_pkg::trk_t d_in,
  output logic               vld_out,
  output rak_pkg::trk_t      d_out
);

  localparam int CSH = 41 - K;
  localparam int HSH = 30 + K;

  rak_pkg::trk_t              d_nxt;
  rak_pkg::trk_t              d_r;
  logic                       vld_r;
  logic [rak_pkg::CW-1:0]     cor_in, cor_out;
  logic [46:0]                hyp_in, hyp_out;

  always_comb begin
    d_nxt   = d_in;
    cor_in  = $unsigned(d_in.x_in | d_in.y_in);
    cor_out = $unsigned(d_in.x_out | d_in.y_out);
    hyp_in  = d_in.hp_in | d_in.hq_in;
    hyp_out = d_in.hp_out | d_in.hq_out;
    // prescale up until one operand reaches bit 40
    if ((cor_in >> CSH) == '0) begin
      d_nxt.x_in = d_in.x_in <<< K;
      d_nxt.y_in = d_in.y_in <<< K;
    end
    if ((cor_out >> CSH) == '0) begin
      d_nxt.x_out = d_in.x_out <<< K;
      d_nxt.y_out = d_in.y_out <<< K;
    end
    // hypot operands down below 2^31 with the smallest shift
    if (K <= 16) begin
      if ((hyp_in >> HSH) != '0) begin
        d_nxt.hp_in = d_in.hp_in >> K;
        d_nxt.hq_in = d_in.hq_in >> K;
        d_nxt.s_in  = d_in.s_in + 5'(K);
      end
      if ((hyp_out >> HSH) != '0) begin
        d_nxt.hp_out = d_in.hp_out >> K;
        d_nxt.hq_out = d_in.hq_out >> K;
        d_nxt.s_out  = d_in.s_out + 5'(K);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

`default_nettype wire

@@ rtl/rak_iter_cell.sv @@
// Iteration cell: one CORDIC vectoring step (only in cells below CORDIC_STEPS) and one square-root digit, both arcs.
`default_nettype none

module rak_iter_cell #(
  parameter int I = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_in,
  input  wire rak_pkg::trk_t d_in,
  output logic               vld_out,
  output rak_pkg::trk_t      d_out
);

  localparam logic [63:0] ONE = 64'd1 << (62 - 2 * I);

  rak_pkg::trk_t                 d_nxt;
  rak_pkg::trk_t                 d_r;
  logic                          vld_r;
  logic signed [rak_pkg::CW-1:0] xi_n, yi_n, xo_n, yo_n;
  logic signed [32:0]            zi_n, zo_n;
  logic [63:0]                   t_in, t_out;

  generate
    if (I < rak_pkg::CORDIC_STEPS) begin : g_cordic
      localparam logic signed [32:0] TAB = 33'($signed({3'b000, rak_pkg::ATAN_TAB[I]}));
      always_comb begin
        if (d_in.y_in >= 0) begin
          xi_n = d_in.x_in + (d_in.y_in >>> I);
          yi_n = d_in.y_in - (d_in.x_in >>> I);
          zi_n = d_in.z_in + TAB;
        end else begin
          xi_n = d_in.x_in - (d_in.y_in >>> I);
          yi_n = d_in.y_in + (d_in.x_in >>> I);
          zi_n = d_in.z_in - TAB;
        end
        if (d_in.y_out >= 0) begin
          xo_n = d_in.x_out + (d_in.y_out >>> I);
          yo_n = d_in.y_out - (d_in.x_out >>> I);
          zo_n = d_in.z_out + TAB;
        end else begin
          xo_n = d_in.x_out - (d_in.y_out >>> I);
          yo_n = d_in.y_out + (d_in.x_out >>> I);
          zo_n = d_in.z_out - TAB;
        end
      end
    end else begin : g_hold
      assign xi_n = d_in.x_in;
      assign yi_n = d_in.y_in;
      assign zi_n = d_in.z_in;
      assign xo_n = d_in.x_out;
      assign yo_n = d_in.y_out;
      assign zo_n = d_in.z_out;
    end
  endgenerate

  always_comb begin
    d_nxt       = d_in;
    d_nxt.x_in  = xi_n;
    d_nxt.y_in  = yi_n;
    d_nxt.z_in  = zi_n;
    d_nxt.x_out = xo_n;
    d_nxt.y_out = yo_n;
    d_nxt.z_out = zo_n;
    t_in        = d_in.r_in + ONE;
    t_out       = d_in.r_out + ONE;
    if (d_in.n_in >= t_in) begin
      d_nxt.n_in = d_in.n_in - t_in;
      d_nxt.r_in = (d_in.r_in >> 1) + ONE;
    end else begin
      d_nxt.r_in = d_in.r_in >> 1;
    end
    if (d_in.n_out >= t_out) begin
      d_nxt.n_out = d_in.n_out - t_out;
      d_nxt.r_out = (d_in.r_out >> 1) + ONE;
    end else begin
      d_nxt.r_out = d_in.r_out >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

`default_nettype wire

@@ rtl/rak_div_cell.sv @@
// Divider cell: one restoring quotient bit for each of the four wheel lanes.
`default_nettype none

module rak_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic [31:0]   dvs,
  input  wire logic          vld_in,
  input  wire rak_pkg::dvp_t d_in,
  output logic               vld_out,
  output rak_pkg::dvp_t      d_out
);

  rak_pkg::dvp_t d_nxt;
  rak_pkg::dvp_t d_r;
  logic          vld_r;
  logic [32:0]   t [rak_pkg::NLANES];

  always_comb begin
    d_nxt = d_in;
    for (int k = 0; k < rak_pkg::NLANES; k++) begin
      t[k] = {d_in.lane[k].rem, d_in.lane[k].lo[31]};
      d_nxt.lane[k].lo = {d_in.lane[k].lo[30:0], 1'b0};
      if (t[k] >= {1'b0, dvs}) begin
        d_nxt.lane[k].rem = 32'(t[k] - {1'b0, dvs});
        d_nxt.lane[k].q   = {d_in.lane[k].q[30:0], 1'b1};
      end else begin
        d_nxt.lane[k].rem = t[k][31:0];
        d_nxt.lane[k].q   = {d_in.lane[k].q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule

`default_nettype wire

@@ rtl/rear_ackermann_kinematics.sv @@
// Rear-axle Ackermann kinematics: velocity command to rear steer angles and wheel rates.
//
// Usage notes:
//  - in_cmd carries one request: forward_speed and yaw_rate, signed Q16.16.
//  - out_res carries one result per request: left/right rear steer angle
//    (signed Q2.16 rad, right already negated) and four wheel rates (Q16.16 rad/s).
//  - A request is taken when valid and ready are both high at a clock edge.
//  - Throughput is one request per cycle while the pipe is not halted. The
//    depth is set by the 32-stage square-root and 32-stage wheel-rate divider
//    chains, plus prescale and setup stages.
//  - The pipe moves as one; it halts only while its last stage holds a result
//    and the output register is full and not taken, so requests keep entering
//    while a finished result waits on out_res.
//  - Registers (APB, byte address 4*i): speed limit, wheelbase, track,
//    wheel radius, steer limit. Write only while idle.
//  - rst_n (synchronous) empties the pipe, holds in_cmd.ready low and restores
//    register defaults.
`default_nettype none

module rear_ackermann_kinematics (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rak_in_if.sink     in_cmd,
  rak_out_if.source  out_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NS = rak_pkg::NORM_STEPS;
  localparam int IS = rak_pkg::SQRT_STEPS;
  localparam int DS = rak_pkg::DIV_STEPS;
  localparam int NL = rak_pkg::NLANES;

  // ---------------------------------------------------------------- registers
  logic [30:0] spd_lim_r, wheelbase_r, track_r, radius_r;
  logic [16:0] max_steer_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_lim_r   <= 31'd65536;
      wheelbase_r <= 31'd65536;
      track_r     <= 31'd65536;
      radius_r    <= 31'd6554;
      max_steer_r <= 17'd32768;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        rak_pkg::REG_SPD_LIM:   spd_lim_r   <= pwdata[30:0];
        rak_pkg::REG_WHEELBASE: wheelbase_r <= pwdata[30:0];
        rak_pkg::REG_TRACK:     track_r     <= pwdata[30:0];
        rak_pkg::REG_RADIUS:    radius_r    <= pwdata[30:0];
        rak_pkg::REG_STEER_LIM: max_steer_r <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      rak_pkg::REG_SPD_LIM:   prdata = {1'b0, spd_lim_r};
      rak_pkg::REG_WHEELBASE: prdata = {1'b0, wheelbase_r};
      rak_pkg::REG_TRACK:     prdata = {1'b0, track_r};
      rak_pkg::REG_RADIUS:    prdata = {1'b0, radius_r};
      rak_pkg::REG_STEER_LIM: prdata = {15'd0, max_steer_r};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic last_vld;
  logic out_vld_r;

  // Whole pipe advances unless a finished result is blocked at the output.
  assign en           = !(last_vld && out_vld_r && !out_res.ready);
  assign in_cmd.ready = en && rst_n;

  // ---------------------------------------------------------------- stage 0
  // clamp speed, take magnitudes
  logic signed [32:0] fs33, ms33, v33;
  logic [30:0]        av_c;
  logic [31:0]        ay_c;

  always_comb begin
    fs33 = 33'(in_cmd.forward_speed);
    ms33 = $signed({2'b00, spd_lim_r});
    if (fs33 > ms33) begin
      v33 = ms33;
    end else if (fs33 < -ms33) begin
      v33 = -ms33;
    end else begin
      v33 = fs33;
    end
    av_c = v33[32] ? 31'(-v33) : v33[30:0];
    ay_c = in_cmd.yaw_rate[31] ? (32'd0 - in_cmd.yaw_rate) : in_cmd.yaw_rate;
  end

  logic        s0_vld_r, s0_vneg_r, s0_yneg_r;
  logic [30:0] s0_av_r;
  logic [31:0] s0_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_vneg_r <= v33[32];
      s0_yneg_r <= in_cmd.yaw_rate[31];
      s0_av_r   <= av_c;
      s0_ay_r   <= ay_c;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // yaw times wheelbase and track
  logic        s1_vld_r, s1_vneg_r, s1_yneg_r;
  logic [30:0] s1_av_r;
  logic [62:0] s1_x_r, s1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vneg_r <= s0_vneg_r;
      s1_yneg_r <= s0_yneg_r;
      s1_av_r   <= s0_av_r;
      s1_x_r    <= 63'(s0_ay_r) * 63'(wheelbase_r);
      s1_t_r    <= 63'(s0_ay_r) * 63'(track_r);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // turn test, half track term, arc lengths
  logic [63:0]   xm, avs, a_sum, b_sum;
  logic [46:0]   a_c, b_c, dout_c, dimag_c;
  logic [47:0]   di48;
  logic          turn_c;
  rak_pkg::trk_t s2_init;

  always_comb begin
    xm      = 64'(s1_x_r[49:0]) * 64'd10000;
    avs     = {17'd0, s1_av_r, 16'd0};
    turn_c  = (s1_av_r > 31'd6) && ((|s1_x_r[62:50]) || (xm > avs));
    a_sum   = 64'(s1_t_r) + 64'd65536;
    b_sum   = 64'(s1_x_r) + 64'd32768;
    a_c     = a_sum[63:17];
    b_c     = b_sum[62:16];
    di48    = {17'd0, s1_av_r} - {1'b0, a_c};
    dimag_c = di48[47] ? 47'(48'd0 - di48) : di48[46:0];
    dout_c  = 47'(s1_av_r) + a_c;

    s2_init        = '0;
    s2_init.turn   = turn_c;
    s2_init.left   = (s1_vneg_r == s1_yneg_r);
    s2_init.v_neg  = s1_vneg_r;
    s2_init.di_neg = di48[47];
    s2_init.av     = s1_av_r;
    s2_init.b      = b_c;
    s2_init.di_mag = dimag_c;
    s2_init.dout   = dout_c;
    s2_init.x_in   = $signed({5'd0, dimag_c});
    s2_init.y_in   = $signed({5'd0, b_c});
    s2_init.x_out  = $signed({5'd0, dout_c});
    s2_init.y_out  = $signed({5'd0, b_c});
    s2_init.hp_in  = b_c;
    s2_init.hq_in  = dimag_c;
    s2_init.hp_out = b_c;
    s2_init.hq_out = dout_c;
  end

  logic          s2_vld_r;
  rak_pkg::trk_t s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_init;
    end
  end

  // ---------------------------------------------------------------- prescale
  logic          nv [NS+1];
  rak_pkg::trk_t nd [NS+1];

  assign nv[0] = s2_vld_r;
  assign nd[0] = s2_r;

  for (genvar j = 0; j < NS; j++) begin : g_norm
    rak_norm_cell #(.K(32 >> j)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(nv[j]), .d_in(nd[j]),
      .vld_out(nv[j+1]), .d_out(nd[j+1])
    );
  end

  // ---------------------------------------------------------------- squares
  // squares parked in n/r, summed into n on the next stage
  logic          sq_vld_r, sm_vld_r;
  rak_pkg::trk_t sq_nxt, sq_r, sm_nxt, sm_r;

  always_comb begin
    sq_nxt       = nd[NS];
    sq_nxt.n_in  = 64'(nd[NS].hp_in[30:0])  * 64'(nd[NS].hp_in[30:0]);
    sq_nxt.r_in  = 64'(nd[NS].hq_in[30:0])  * 64'(nd[NS].hq_in[30:0]);
    sq_nxt.n_out = 64'(nd[NS].hp_out[30:0]) * 64'(nd[NS].hp_out[30:0]);
    sq_nxt.r_out = 64'(nd[NS].hq_out[30:0]) * 64'(nd[NS].hq_out[30:0]);
    sm_nxt       = sq_r;
    sm_nxt.n_in  = sq_r.n_in + sq_r.r_in;
    sm_nxt.r_in  = '0;
    sm_nxt.n_out = sq_r.n_out + sq_r.r_out;
    sm_nxt.r_out = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      sm_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r <= nv[NS];
      sm_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
      sm_r <= sm_nxt;
    end
  end

  // ---------------------------------------------------------------- CORDIC + sqrt
  logic          iv [IS+1];
  rak_pkg::trk_t id [IS+1];

  assign iv[0] = sm_vld_r;
  assign id[0] = sm_r;

  for (genvar j = 0; j < IS; j++) begin : g_iter
    rak_iter_cell #(.I(j)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(iv[j]), .d_in(id[j]),
      .vld_out(iv[j+1]), .d_out(id[j+1])
    );
  end

  // ---------------------------------------------------------------- finish
  // angles from z, hypot shift back, lane assignment by turn side
  rak_pkg::trk_t      fd;
  logic signed [32:0] zc_in, zc_out, zr_in, zr_out;
  logic signed [17:0] at_in, at_out, ia, oa;
  logic [48:0]        hyp_in, hyp_out, di49, do49, av49;
  rak_pkg::fin_t      fin_nxt;

  always_comb begin
    fd = id[IS];
    if (fd.z_in < 0) begin
      zc_in = '0;
    end else if (fd.z_in > rak_pkg::HALF_PI_Q30) begin
      zc_in = rak_pkg::HALF_PI_Q30;
    end else begin
      zc_in = fd.z_in;
    end
    if (fd.z_out < 0) begin
      zc_out = '0;
    end else if (fd.z_out > rak_pkg::HALF_PI_Q30) begin
      zc_out = rak_pkg::HALF_PI_Q30;
    end else begin
      zc_out = fd.z_out;
    end
    zr_in  = (zc_in + 33'sd8192) >>> 14;
    zr_out = (zc_out + 33'sd8192) >>> 14;
    at_in  = $signed({1'b0, zr_in[16:0]});
    at_out = $signed({1'b0, zr_out[16:0]});

    // zero inner arc points straight sideways; zero numerator means no angle
    if (fd.di_mag == '0) begin
      ia = rak_pkg::HALF_PI_Q16;
    end else if (fd.b == '0) begin
      ia = '0;
    end else begin
      ia = fd.di_neg ? -at_in : at_in;
    end
    oa = (fd.b == '0) ? 18'sd0 : at_out;

    hyp_in  = {17'd0, fd.r_in[31:0]} << fd.s_in;
    hyp_out = {17'd0, fd.r_out[31:0]} << fd.s_out;
    di49    = {2'b00, fd.di_mag};
    do49    = {2'b00, fd.dout};
    av49    = {18'd0, fd.av};

    fin_nxt = '0;
    if (!fd.turn) begin
      fin_nxt.la  = '0;
      fin_nxt.ra  = '0;
      fin_nxt.neg = {NL{fd.v_neg}};
      for (int k = 0; k < NL; k++) begin
        fin_nxt.mag[k] = av49;
      end
    end else if (fd.left) begin
      fin_nxt.la     = ia;
      fin_nxt.ra     = oa;
      fin_nxt.neg    = {fd.v_neg, fd.v_neg, fd.v_neg, fd.v_neg ^ fd.di_neg};
      fin_nxt.mag[0] = di49;
      fin_nxt.mag[1] = do49;
      fin_nxt.mag[2] = hyp_in;
      fin_nxt.mag[3] = hyp_out;
    end else begin
      fin_nxt.la     = -oa;
      fin_nxt.ra     = -ia;
      fin_nxt.neg    = {fd.v_neg, fd.v_neg, fd.v_neg ^ fd.di_neg, fd.v_neg};
      fin_nxt.mag[0] = do49;
      fin_nxt.mag[1] = di49;
      fin_nxt.mag[2] = hyp_out;
      fin_nxt.mag[3] = hyp_in;
    end
  end

  logic          fin_vld_r;
  rak_pkg::fin_t fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= iv[IS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // ---------------------------------------------------------------- divider setup
  // rate = round(mag * 2^16 / r) = floor((mag * 2^17 + r) / (2r))
  logic [30:0]        wr;
  logic [31:0]        dvs;
  logic signed [17:0] lim, la_c, ra_c;
  logic [66:0]        num [NL];
  rak_pkg::dvp_t      dv_nxt;

  assign wr  = (radius_r == '0) ? 31'd1 : radius_r;
  assign dvs = {wr, 1'b0};

  always_comb begin
    lim = $signed({1'b0, max_steer_r});
    if (fin_r.la > lim) begin
      la_c = lim;
    end else if (fin_r.la < -lim) begin
      la_c = -lim;
    end else begin
      la_c = fin_r.la;
    end
    if (fin_r.ra > lim) begin
      ra_c = lim;
    end else if (fin_r.ra < -lim) begin
      ra_c = -lim;
    end else begin
      ra_c = fin_r.ra;
    end
    dv_nxt    = '0;
    dv_nxt.la = la_c;
    dv_nxt.ra = -ra_c;
    for (int k = 0; k < NL; k++) begin
      num[k]             = {1'b0, fin_r.mag[k], 17'd0} + 67'(wr);
      dv_nxt.lane[k].neg = fin_r.neg[k];
      // quotient of 2^32 or more saturates regardless of low bits
      dv_nxt.lane[k].sat = (num[k][66:32] >= {3'd0, dvs});
      dv_nxt.lane[k].rem = dv_nxt.lane[k].sat ? 32'd0 : num[k][63:32];
      dv_nxt.lane[k].lo  = num[k][31:0];
      dv_nxt.lane[k].q   = '0;
    end
  end

  logic          dv_vld_r;
  rak_pkg::dvp_t dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= 1'b0;
    end else if (en) begin
      dv_vld_r <= fin_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r <= dv_nxt;
    end
  end

  // ---------------------------------------------------------------- divider chain
  logic          dvv [DS+1];
  rak_pkg::dvp_t dvd [DS+1];

  assign dvv[0] = dv_vld_r;
  assign dvd[0] = dv_r;

  for (genvar j = 0; j < DS; j++) begin : g_div
    rak_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .dvs(dvs),
      .vld_in(dvv[j]), .d_in(dvd[j]),
      .vld_out(dvv[j+1]), .d_out(dvd[j+1])
    );
  end

  assign last_vld = dvv[DS];

  // ---------------------------------------------------------------- output
  // saturate to signed 32 bits, apply sign
  logic [31:0] rate_c [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      if (dvd[DS].lane[k].neg) begin
        if (dvd[DS].lane[k].sat || dvd[DS].lane[k].q >= 32'h8000_0000) begin
          rate_c[k] = 32'h8000_0000;
        end else begin
          rate_c[k] = 32'd0 - dvd[DS].lane[k].q;
        end
      end else begin
        if (dvd[DS].lane[k].sat || dvd[DS].lane[k].q > 32'h7FFF_FFFF) begin
          rate_c[k] = 32'h7FFF_FFFF;
        end else begin
          rate_c[k] = dvd[DS].lane[k].q;
        end
      end
    end
  end

  logic signed [17:0] out_la_r, out_ra_r;
  logic [31:0]        out_fl_r, out_fr_r, out_rl_r, out_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_res.ready || !out_vld_r) begin
      out_vld_r <= last_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_res.ready || !out_vld_r) begin
      out_la_r <= dvd[DS].la;
      out_ra_r <= dvd[DS].ra;
      out_fl_r <= rate_c[0];
      out_fr_r <= rate_c[1];
      out_rl_r <= rate_c[2];
      out_rr_r <= rate_c[3];
    end
  end

  assign out_res.valid             = out_vld_r;
  assign out_res.left_steer_angle  = out_la_r;
  assign out_res.right_steer_angle = out_ra_r;
  assign out_res.front_left_rate   = $signed(out_fl_r);
  assign out_res.front_right_rate  = $signed(out_fr_r);
  assign out_res.rear_left_rate    = $signed(out_rl_r);
  assign out_res.rear_right_rate   = $signed(out_rr_r);

endmodule

`default_nettype wire
